[sv/sgbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbl_pkg
// Shared types for the stable group-by-length sorter: item structs, the
// cell operation code and the sequencer states.
// ----------------------------------------------------------------------------
package sgbl_pkg;

	localparam int unsigned IN_LEN_W  = 8;
	localparam int unsigned OUT_IDX_W = 6;
	localparam int unsigned OUT_LEN_W = 8;

	typedef struct packed {
		logic [IN_LEN_W-1:0] word_length;
		logic                last_word;
	} in_item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] word_index;
		logic [OUT_LEN_W-1:0] length_out;
		logic                 group_last;
		logic                 list_last;
		logic                 overflow;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_HOLD  = 3'b001,
		OP_LOAD  = 3'b010,
		OP_SHIFT = 3'b100
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

endpackage

[sv/sgbl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbl_cell
// One slot of the sorted chain: holds a length and its load index, takes a
// new item or its left neighbour's entry on insertion, and its right
// neighbour's entry while the chain drains.
// ----------------------------------------------------------------------------
module sgbl_cell #(
	parameter int unsigned KW = 8,
	parameter int unsigned IW = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sgbl_pkg::cell_op_t op,
	input  logic [KW-1:0]     new_key,
	input  logic [IW-1:0]     new_idx,
	input  logic              left_keep,
	input  logic [KW-1:0]     left_key,
	input  logic [IW-1:0]     left_idx,
	input  logic              left_vld,
	input  logic [KW-1:0]     right_key,
	input  logic [IW-1:0]     right_idx,
	input  logic              right_vld,
	output logic [KW-1:0]     key_q,
	output logic [IW-1:0]     idx_q,
	output logic              vld_q,
	output logic              keep
);
	import sgbl_pkg::*;

	// equal keys stay ahead of the new item, which keeps load order
	assign keep = vld_q && (key_q <= new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (!keep) begin
						vld_q <= left_keep ? 1'b1 : left_vld;
					end
				end
				OP_SHIFT: vld_q <= right_vld;
				default:  vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (!keep) begin
					if (left_keep) begin
						key_q <= new_key;
						idx_q <= new_idx;
					end else begin
						key_q <= left_key;
						idx_q <= left_idx;
					end
				end
			end
			OP_SHIFT: begin
				key_q <= right_key;
				idx_q <= right_idx;
			end
			default: begin
				key_q <= key_q;
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

[sv/stable_group_by_length.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_group_by_length
// Loads word lengths into a sorted chain of cells (stable insertion), then
// drains the chain in order, one result per cycle.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     start / busy     in_item  (word_length, last_word)
//  result    valid (strobe)   result   (word_index, length_out, group_last,
//                                       list_last, overflow)
//
//  loading: one item per cycle while busy is low; the cell chain does the
//  whole insertion at once. an item marked last starts the drain: N results
//  for N stored words, back to back, after the state register enters the
//  drain and the head entry is registered, with busy high until the final
//  result is registered. reset clears the chain's valid bits, count and
//  flags; no clearing pass. results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module stable_group_by_length #(
	parameter int unsigned MAX_WORDS   = 64,
	parameter int unsigned LENGTH_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  sgbl_pkg::in_item_t   in_item,
	output logic                 busy,
	output logic                 valid,
	output sgbl_pkg::out_item_t  result
);
	import sgbl_pkg::*;

	localparam int unsigned KW = LENGTH_BITS;
	localparam int unsigned IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned CW = $clog2(MAX_WORDS + 1);

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           overflow_q;
	logic           valid_q;
	out_item_t      result_q;

	logic           accept;
	logic           full;
	cell_op_t       op;
	logic [KW-1:0]  new_key;
	logic [IW-1:0]  new_idx;

	logic [KW-1:0]  key_c   [MAX_WORDS];
	logic [IW-1:0]  idx_c   [MAX_WORDS];
	logic           vld_c   [MAX_WORDS];
	logic           keep_c  [MAX_WORDS];
	logic           lkeep   [MAX_WORDS];
	logic [KW-1:0]  lkey    [MAX_WORDS];
	logic [IW-1:0]  lidx    [MAX_WORDS];
	logic           lvld    [MAX_WORDS];
	logic [KW-1:0]  rkey    [MAX_WORDS];
	logic [IW-1:0]  ridx    [MAX_WORDS];
	logic           rvld    [MAX_WORDS];

	logic           head_glast;
	logic           head_llast;

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(MAX_WORDS));
	assign new_idx = count_q[IW-1:0];

	always_comb begin
		for (int b = 0; b < KW; b++) begin
			new_key[b] = (b < IN_LEN_W) ? in_item.word_length[b] : 1'b0;
		end
	end

	always_comb begin
		if (accept && !full) begin
			op = OP_LOAD;
		end else if (state_q == ST_EMIT) begin
			op = OP_SHIFT;
		end else begin
			op = OP_HOLD;
		end
	end

	// neighbour wiring of the chain
	for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign lkeep[i] = 1'b1;
			assign lkey[i]  = '0;
			assign lidx[i]  = '0;
			assign lvld[i]  = 1'b0;
		end else begin : g_mid
			assign lkeep[i] = keep_c[i-1];
			assign lkey[i]  = key_c[i-1];
			assign lidx[i]  = idx_c[i-1];
			assign lvld[i]  = vld_c[i-1];
		end
		if (i == MAX_WORDS - 1) begin : g_tail
			assign rkey[i] = '0;
			assign ridx[i] = '0;
			assign rvld[i] = 1'b0;
		end else begin : g_body
			assign rkey[i] = key_c[i+1];
			assign ridx[i] = idx_c[i+1];
			assign rvld[i] = vld_c[i+1];
		end

		sgbl_cell #(
			.KW(KW),
			.IW(IW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.new_key  (new_key),
			.new_idx  (new_idx),
			.left_keep(lkeep[i]),
			.left_key (lkey[i]),
			.left_idx (lidx[i]),
			.left_vld (lvld[i]),
			.right_key(rkey[i]),
			.right_idx(ridx[i]),
			.right_vld(rvld[i]),
			.key_q    (key_c[i]),
			.idx_q    (idx_c[i]),
			.vld_q    (vld_c[i]),
			.keep     (keep_c[i])
		);
	end

	assign head_llast = !vld_c[1];
	assign head_glast = !vld_c[1] || (key_c[1] != key_c[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= (state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (in_item.last_word) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (head_llast) begin
						state_q    <= ST_IDLE;
						count_q    <= '0;
						overflow_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			for (int b = 0; b < OUT_IDX_W; b++) begin
				result_q.word_index[b] <= (b < IW) ? idx_c[0][b] : 1'b0;
			end
			for (int b = 0; b < OUT_LEN_W; b++) begin
				result_q.length_out[b] <= (b < KW) ? key_c[0][b] : 1'b0;
			end
			result_q.group_last <= head_glast;
			result_q.list_last  <= head_llast;
			result_q.overflow   <= overflow_q;
		end
	end

	assign valid  = valid_q;
	assign result = result_q;

endmodule

[sv/sgbl_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgbl_check
// Port-level checks for the stable group-by-length sorter.
// ----------------------------------------------------------------------------
module sgbl_check (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input sgbl_pkg::in_item_t  in_item,
	input logic                busy,
	input logic                valid,
	input sgbl_pkg::out_item_t result
);
	import sgbl_pkg::*;

	// a last item always starts a drain
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_item.last_word |=> busy)
		else $error("last item did not start the drain");

	// results come back to back until the final one
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.list_last |=> valid)
		else $error("gap inside a result burst");

	a_busy_during: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.list_last |-> busy)
		else $error("not busy while results remain");

	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.list_last |-> result.group_last)
		else $error("final result does not close its group");

	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && result.list_last)
		else $error("busy dropped without a final result");

endmodule

bind stable_group_by_length sgbl_check u_sgbl_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.in_item(in_item),
	.busy   (busy),
	.valid  (valid),
	.result (result)
);
